// ===== hw/rtl/screen_melt_column_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Screen melt column engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SCREEN_MELT_COLUMN_ENGINE_DEFINES_SVH
`define SCREEN_MELT_COLUMN_ENGINE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SMC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// Screen melt column engine package
// Defaults, mode codes, melt constants and sequencer states.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int DEF_SCREEN_COLUMNS = 320;
    localparam int DEF_SCREEN_ROWS    = 200;

    localparam logic [1:0] MODE_SEED  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Non-negative offsets below this grow by offset + 1, at or above it by SLOW_STEP.
    localparam int FAST_LIMIT = 16;
    localparam int SLOW_STEP  = 8;
    localparam int MIN_DELAY  = -15;

    // r / 3 == (r * MOD3_RECIP) >> MOD3_SHIFT for any 8-bit r.
    localparam int MOD3_RECIP = 171;
    localparam int MOD3_SHIFT = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_RD,
        ST_SEED_WR0,
        ST_SEED_WR1,
        ST_TICK,
        ST_TICK_LAST,
        ST_QUERY
    } state_t;

endpackage

// ===== hw/rtl/screen_melt_column_engine.sv =====
// ----------------------------------------------------------------------------
// Screen melt column engine
// Holds one signed delay/offset per screen column in a single memory and
// serves three transactions, each with exactly one result strobe: seed the
// next column pair, advance every column by one tick (one column per cycle
// through the memory read/write ports), and answer a pixel source query (one
// memory read). Unused mode codes and out-of-range queries answer all zeros.
// busy is high while a transaction runs; a new one is taken in the cycle its
// predecessor's result is shown. A result is marked by valid for one cycle
// only; the receiver cannot stall it. Offsets are undefined after reset until
// seeded, and there is no clearing pass.
// ----------------------------------------------------------------------------
`include "screen_melt_column_engine_defines.svh"

module screen_melt_column_engine #(
    parameter int SCREEN_COLUMNS = smc_pkg::DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = smc_pkg::DEF_SCREEN_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [7:0] random_byte,
    input  logic [8:0] column,
    input  logic [7:0] row,
    output logic       valid,
    output logic       source_frame,
    output logic [7:0] source_row,
    output logic       done_res
);

    localparam int AW         = $clog2(SCREEN_COLUMNS);
    localparam int PAIR_COUNT = (SCREEN_COLUMNS + 1) / 2;
    localparam int PIW        = $clog2(PAIR_COUNT + 1);
    localparam int OW         = $clog2(SCREEN_ROWS + 1) + 1;
    localparam int SW         = OW + 1;
    localparam int CCW        = $clog2(SCREEN_COLUMNS + 1);
    localparam int CMPW       = (CCW > 9) ? CCW : 10;
    localparam int YW         = (OW > 9) ? OW : 9;

    localparam logic [CMPW-1:0]      COLS_C    = CMPW'(SCREEN_COLUMNS);
    localparam logic [AW:0]          COLS_F    = (AW + 1)'(SCREEN_COLUMNS);
    localparam logic [AW-1:0]        LAST_COL  = AW'(SCREEN_COLUMNS - 1);
    localparam logic [PIW-1:0]       LAST_PAIR = PIW'(PAIR_COUNT - 1);
    localparam logic signed [SW-1:0] ROWS_S    = SW'(SCREEN_ROWS);
    localparam logic signed [SW-1:0] ONE_S     = SW'(1);
    localparam logic signed [SW-1:0] ZERO_S    = '0;
    localparam logic signed [SW-1:0] FAST_S    = SW'(smc_pkg::FAST_LIMIT);
    localparam logic signed [SW-1:0] SLOW_S    = SW'(smc_pkg::SLOW_STEP);
    localparam logic signed [SW-1:0] MIN_S     = SW'(smc_pkg::MIN_DELAY);
    localparam logic signed [YW-1:0] ROWS_Y    = YW'(SCREEN_ROWS);
    localparam logic signed [YW-1:0] ZERO_Y    = '0;

    smc_pkg::state_t state_reg, state_next;

    logic [PIW-1:0]       pair_idx_reg, pair_idx_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        wr_col_reg, wr_col_next;
    logic                 pend_reg, pend_next;
    logic                 moving_reg, moving_next;
    logic [7:0]           r_reg, r_next;
    logic [7:0]           row_reg, row_next;
    logic signed [OW-1:0] seed_val_reg, seed_val_next;
    logic                 valid_reg, valid_next;
    logic                 frame_reg, frame_next;
    logic [7:0]           srow_reg, srow_next;
    logic                 done_reg, done_next;

    logic                 accept;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [OW-1:0]        mem_wr_data;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [OW-1:0]        mem_rd_data;
    logic signed [OW-1:0] rd_s;

    logic [CMPW-1:0]      col_cmp;
    logic                 q_in_range;
    logic [AW:0]          first_w;
    logic [AW:0]          first_m1;
    logic [AW:0]          second_w;

    logic signed [SW-1:0] seed0_s;
    logic [16:0]          m3_prod;
    logic [7:0]           m3_q;
    logic [7:0]           m3_q3;
    logic [7:0]           m3_diff;
    logic signed [SW-1:0] seed_prev;
    logic signed [SW-1:0] seed_sum;
    logic signed [SW-1:0] seed_clamp;

    logic signed [SW-1:0] p_t;
    logic signed [SW-1:0] tick_inc;
    logic signed [SW-1:0] tick_dy;
    logic signed [SW-1:0] tick_sum;
    logic signed [SW-1:0] tick_res;
    logic                 tick_moving;

    logic signed [YW-1:0] p_y;
    logic signed [YW-1:0] y_y;
    logic signed [YW-1:0] q_diff;
    logic                 q_frame;
    logic [7:0]           q_row;

    smc_offset_ram #(
        .DEPTH(SCREEN_COLUMNS),
        .WIDTH(OW)
    ) u_ram (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    assign busy   = (state_reg != smc_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign rd_s   = $signed(mem_rd_data);

    assign valid        = valid_reg;
    assign source_frame = frame_reg;
    assign source_row   = srow_reg;
    assign done_res     = done_reg;

    // Address and range decode
    assign col_cmp    = CMPW'(column);
    assign q_in_range = (col_cmp < COLS_C) && ($signed(YW'(row)) < ROWS_Y);
    assign first_w    = (AW + 1)'(pair_idx_reg) << 1;
    assign first_m1   = first_w - (AW + 1)'(1);
    assign second_w   = first_w + (AW + 1)'(1);

    // Seed arithmetic
    assign seed0_s   = -$signed({{(SW - 4){1'b0}}, random_byte[3:0]});
    assign m3_prod   = 17'(r_reg) * 17'(smc_pkg::MOD3_RECIP);
    assign m3_q      = 8'(m3_prod >> smc_pkg::MOD3_SHIFT);
    assign m3_q3     = {m3_q[6:0], 1'b0} + m3_q;
    assign m3_diff   = r_reg - m3_q3;
    assign seed_prev = SW'(rd_s);
    assign seed_sum  = seed_prev + $signed({{(SW - 2){1'b0}}, m3_diff[1:0]}) - ONE_S;

    always_comb
    begin
        priority if (seed_sum > ZERO_S)
        begin
            seed_clamp = ZERO_S;
        end
        else if (seed_sum < MIN_S)
        begin
            seed_clamp = MIN_S;
        end
        else
        begin
            seed_clamp = seed_sum;
        end
    end

    // Tick arithmetic
    assign p_t      = SW'(rd_s);
    assign tick_inc = p_t + ONE_S;
    assign tick_dy  = (p_t < FAST_S) ? tick_inc : SLOW_S;
    assign tick_sum = p_t + tick_dy;

    always_comb
    begin
        tick_moving = 1'b1;
        priority if (p_t[SW-1])
        begin
            tick_res = tick_inc;
        end
        else if (p_t < ROWS_S)
        begin
            tick_res = (tick_sum >= ROWS_S) ? ROWS_S : tick_sum;
        end
        else
        begin
            tick_res    = p_t;
            tick_moving = 1'b0;
        end
    end

    // Query arithmetic
    assign p_y    = YW'(rd_s);
    assign y_y    = $signed(YW'(row_reg));
    assign q_diff = y_y - p_y;

    always_comb
    begin
        q_frame = 1'b0;
        q_row   = row_reg;
        priority if (p_y <= ZERO_Y)
        begin
            q_row = row_reg;
        end
        else if (y_y < p_y)
        begin
            q_frame = 1'b1;
        end
        else
        begin
            q_row = q_diff[7:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        smc_pkg::MODE_SEED:
                            state_next = (pair_idx_reg == '0) ? smc_pkg::ST_SEED_WR0
                                                              : smc_pkg::ST_SEED_RD;
                        smc_pkg::MODE_TICK:
                            state_next = smc_pkg::ST_TICK;
                        smc_pkg::MODE_QUERY:
                            state_next = q_in_range ? smc_pkg::ST_QUERY : smc_pkg::ST_IDLE;
                        default:
                            state_next = smc_pkg::ST_IDLE;
                    endcase
                end
            end
            smc_pkg::ST_SEED_RD:   state_next = smc_pkg::ST_SEED_WR0;
            smc_pkg::ST_SEED_WR0:  state_next = smc_pkg::ST_SEED_WR1;
            smc_pkg::ST_SEED_WR1:  state_next = smc_pkg::ST_IDLE;
            smc_pkg::ST_TICK:
                state_next = (cnt_reg == LAST_COL) ? smc_pkg::ST_TICK_LAST : smc_pkg::ST_TICK;
            smc_pkg::ST_TICK_LAST: state_next = smc_pkg::ST_IDLE;
            smc_pkg::ST_QUERY:     state_next = smc_pkg::ST_IDLE;
            default:               state_next = smc_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and register next values
    always_comb
    begin
        pair_idx_next = pair_idx_reg;
        cnt_next      = cnt_reg;
        wr_col_next   = wr_col_reg;
        pend_next     = pend_reg;
        moving_next   = moving_reg;
        r_next        = r_reg;
        row_next      = row_reg;
        seed_val_next = seed_val_reg;
        valid_next    = 1'b0;
        frame_next    = frame_reg;
        srow_next     = srow_reg;
        done_next     = done_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = wr_col_reg;
        mem_wr_data   = tick_res[OW-1:0];
        mem_rd_en     = 1'b0;
        mem_rd_addr   = cnt_reg;

        unique case (state_reg)
            smc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    r_next   = random_byte;
                    row_next = row;
                    unique case (mode)
                        smc_pkg::MODE_SEED:
                        begin
                            if (pair_idx_reg == '0)
                            begin
                                seed_val_next = seed0_s[OW-1:0];
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = first_m1[AW-1:0];
                            end
                        end
                        smc_pkg::MODE_TICK:
                        begin
                            cnt_next    = '0;
                            moving_next = 1'b0;
                            pend_next   = 1'b0;
                        end
                        smc_pkg::MODE_QUERY:
                        begin
                            if (q_in_range)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = col_cmp[AW-1:0];
                            end
                            else
                            begin
                                valid_next = 1'b1;
                                frame_next = 1'b0;
                                srow_next  = '0;
                                done_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            valid_next = 1'b1;
                            frame_next = 1'b0;
                            srow_next  = '0;
                            done_next  = 1'b0;
                        end
                    endcase
                end
            end
            smc_pkg::ST_SEED_RD:
            begin
                seed_val_next = seed_clamp[OW-1:0];
            end
            smc_pkg::ST_SEED_WR0:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = first_w[AW-1:0];
                mem_wr_data = seed_val_reg;
            end
            smc_pkg::ST_SEED_WR1:
            begin
                // Drop the second write when the last pair holds one column.
                mem_wr_en     = (second_w < COLS_F);
                mem_wr_addr   = second_w[AW-1:0];
                mem_wr_data   = seed_val_reg;
                pair_idx_next = (pair_idx_reg == LAST_PAIR) ? '0
                                                            : pair_idx_reg + PIW'(1);
                valid_next    = 1'b1;
                frame_next    = 1'b0;
                srow_next     = '0;
                done_next     = 1'b0;
            end
            smc_pkg::ST_TICK:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_reg;
                pend_next   = 1'b1;
                wr_col_next = cnt_reg;
                cnt_next    = cnt_reg + AW'(1);
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    moving_next = moving_reg | tick_moving;
                end
            end
            smc_pkg::ST_TICK_LAST:
            begin
                mem_wr_en  = 1'b1;
                pend_next  = 1'b0;
                valid_next = 1'b1;
                frame_next = 1'b0;
                srow_next  = '0;
                done_next  = !(moving_reg | tick_moving);
            end
            smc_pkg::ST_QUERY:
            begin
                valid_next = 1'b1;
                frame_next = q_frame;
                srow_next  = q_row;
                done_next  = 1'b0;
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= smc_pkg::ST_IDLE;
            pair_idx_reg <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            moving_reg   <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pair_idx_reg <= pair_idx_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            moving_reg   <= moving_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_col_reg   <= wr_col_next;
        r_reg        <= r_next;
        row_reg      <= row_next;
        seed_val_reg <= seed_val_next;
        frame_reg    <= frame_next;
        srow_reg     <= srow_next;
        done_reg     <= done_next;
    end

    `SMC_ASSERT_NEXT(a_accept_progress, accept, busy || valid, "accepted transaction stalled")
    `SMC_ASSERT_IMPLY(a_result_idle, valid, !busy, "result strobe while still busy")
    `SMC_ASSERT_IMPLY(a_write_range, mem_wr_en, mem_wr_addr <= LAST_COL, "write past last column")
    `SMC_ASSERT_IMPLY(a_pair_range, 1'b1, pair_idx_reg <= LAST_PAIR, "seed pair index out of range")

endmodule

// ===== hw/rtl/smc_offset_ram.sv =====
// ----------------------------------------------------------------------------
// Column offset memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smc_offset_ram #(
    parameter int DEPTH = smc_pkg::DEF_SCREEN_COLUMNS,
    parameter int WIDTH = 9
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
